FILE: src/dwp_pkg.sv
// shared constants, types and tables for the dew point pipeline
`timescale 1ns / 1ps

package dwp_pkg;

    // port widths
    localparam int TEMP_W    = 15;
    localparam int HUM_W     = 14;
    localparam int DEW_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // register reset values
    localparam logic [CFG_W-1:0] A_RESET = 16'd17270;
    localparam logic [CFG_W-1:0] B_RESET = 16'd23770;

    // fixed point constants
    localparam int LN2_Q    = 45426;
    localparam int LN1E4_Q  = 603609;
    localparam int SCALE    = 1000;
    localparam int ROUND_A  = 500;
    localparam int DEW_MAX  = 10000;
    localparam int DEW_MIN_MAG = 27315;

    // divide by 1000 as multiply by ceil(2^38/1000) and shift, exact below 2^32
    localparam int RECIP_1000 = 274877907;
    localparam int RECIP_SH   = 38;

    // internal widths
    localparam int N1_W    = 47;
    localparam int D1_W    = 27;
    localparam int N2_W    = 54;
    localparam int D2_W    = 37;
    localparam int ALPHA_W = 38;
    localparam int LN_W    = 21;
    localparam int AQ_W    = 23;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A = 2'd0,
        CFG_B = 2'd1
    } t_cfg_idx;

    // ln(1 + k/16) in Q0.16, k = 0..15
    function automatic logic [15:0] ln_tab(input logic [3:0] k);
        logic [15:0] v;
        case (k)
            4'd0:    v = 16'd0;
            4'd1:    v = 16'd3973;
            4'd2:    v = 16'd7719;
            4'd3:    v = 16'd11262;
            4'd4:    v = 16'd14624;
            4'd5:    v = 16'd17821;
            4'd6:    v = 16'd20870;
            4'd7:    v = 16'd23783;
            4'd8:    v = 16'd26573;
            4'd9:    v = 16'd29248;
            4'd10:   v = 16'd31818;
            4'd11:   v = 16'd34292;
            4'd12:   v = 16'd36675;
            4'd13:   v = 16'd38975;
            4'd14:   v = 16'd41196;
            4'd15:   v = 16'd43345;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // slope to the next table entry
    function automatic logic [11:0] ln_diff(input logic [3:0] k);
        logic [11:0] v;
        case (k)
            4'd0:    v = 12'd3973;
            4'd1:    v = 12'd3746;
            4'd2:    v = 12'd3543;
            4'd3:    v = 12'd3362;
            4'd4:    v = 12'd3197;
            4'd5:    v = 12'd3049;
            4'd6:    v = 12'd2913;
            4'd7:    v = 12'd2790;
            4'd8:    v = 12'd2675;
            4'd9:    v = 12'd2570;
            4'd10:   v = 12'd2474;
            4'd11:   v = 12'd2383;
            4'd12:   v = 12'd2300;
            4'd13:   v = 12'd2221;
            4'd14:   v = 12'd2149;
            4'd15:   v = 12'd2081;
            default: v = 12'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/dew_point_magnus_top.sv
// dew point pipeline top level: input stages, two divider pipelines, output register
`timescale 1ns / 1ps

// channel   | signals                                   | handshake
// ----------+-------------------------------------------+---------------------------
// input     | i_temp_centi, i_humidity_centi            | i_start, o_busy
// result    | o_dew_centi, o_valid_res, o_overflow      | o_done, one cycle
// config    | i_cfg_index, i_cfg_data                   | i_cfg_valid, o_cfg_ready
//
// one item per cycle; o_busy is always low
// an accepted item passes stage 1, stage 2, the term divider, stages a to d, the dew divider
// and the output register; the two bit-per-stage divider pipelines have 47 and 54 stages
// synchronous active-low reset clears valid bits and restores the registers
// results leave on o_done for one cycle; the receiver cannot stall

module dew_point_magnus_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic signed [dwp_pkg::TEMP_W-1:0]   i_temp_centi,
    input  logic [dwp_pkg::HUM_W-1:0]           i_humidity_centi,
    output logic                                o_done,
    output logic signed [dwp_pkg::DEW_W-1:0]    o_dew_centi,
    output logic                                o_valid_res,
    output logic                                o_overflow,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dwp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dwp_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int N1_W = dwp_pkg::N1_W;
    localparam int D1_W = dwp_pkg::D1_W;
    localparam int N2_W = dwp_pkg::N2_W;
    localparam int D2_W = dwp_pkg::D2_W;
    localparam int AW   = dwp_pkg::ALPHA_W;
    localparam int LW   = dwp_pkg::LN_W;
    localparam int QW   = dwp_pkg::AQ_W;

    // configuration registers
    logic [15:0] r_a;
    logic [15:0] r_b;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= dwp_pkg::A_RESET;
            r_b <= dwp_pkg::B_RESET;
        end else if (i_cfg_valid) begin
            case (dwp_pkg::t_cfg_idx'(i_cfg_index))
                dwp_pkg::CFG_A: r_a <= i_cfg_data;
                dwp_pkg::CFG_B: r_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a_q = round(a * 65536 / 1000) by reciprocal multiply, registered, so it follows r_a in the next cycle
    logic [31:0]   n_aq_num;
    logic [60:0]   n_aq_prod;
    logic [QW-1:0] r_aq;

    always_comb begin
        n_aq_num  = {r_a, 16'b0} + 32'(dwp_pkg::ROUND_A);
        n_aq_prod = 61'(n_aq_num) * 61'(dwp_pkg::RECIP_1000);
    end

    always_ff @(posedge i_clk) begin
        r_aq <= n_aq_prod[dwp_pkg::RECIP_SH +: QW];
    end

    // stage 1: |t|*a, b+t, humidity normalize
    logic        n_s1_tneg;
    logic [14:0] n_s1_tmag;
    logic [30:0] n_s1_mag_at;
    logic [17:0] n_s1_den1;
    logic [3:0]  n_s1_p;
    logic [29:0] n_s1_shift;

    always_comb begin
        n_s1_tneg   = i_temp_centi[14];
        n_s1_tmag   = n_s1_tneg ? 15'(-i_temp_centi) : 15'(i_temp_centi);
        n_s1_mag_at = 31'(r_a) * 31'(n_s1_tmag);
        n_s1_den1   = {2'b00, r_b} + {{3{i_temp_centi[14]}}, i_temp_centi};
        n_s1_p      = 4'd0;
        for (int i = 0; i < dwp_pkg::HUM_W; i++) begin
            if (i_humidity_centi[i]) begin
                n_s1_p = 4'(i);
            end
        end
        n_s1_shift  = {i_humidity_centi, 16'b0} >> n_s1_p;
    end

    logic        r_s1_v;
    logic        r_s1_tneg;
    logic [30:0] r_s1_mag_at;
    logic [17:0] r_s1_den1;
    logic        r_s1_hzero;
    logic [3:0]  r_s1_p;
    logic [3:0]  r_s1_idx;
    logic [11:0] r_s1_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_tneg   <= n_s1_tneg;
        r_s1_mag_at <= n_s1_mag_at;
        r_s1_den1   <= n_s1_den1;
        r_s1_hzero  <= (i_humidity_centi == '0);
        r_s1_p      <= n_s1_p;
        r_s1_idx    <= n_s1_shift[15:12];
        r_s1_w      <= n_s1_shift[11:0];
    end

    // stage 2: divider operands and ln table interpolation
    logic [16:0]   n_s2_den1_mag;
    logic [D1_W-1:0] n_s2_den;
    logic [N1_W-1:0] n_s2_num;
    logic [LW-1:0] n_s2_lnbase;
    logic [23:0]   n_s2_prod;

    always_comb begin
        n_s2_den1_mag = r_s1_den1[17] ? 17'(-r_s1_den1) : r_s1_den1[16:0];
        n_s2_den      = D1_W'(n_s2_den1_mag) * D1_W'(dwp_pkg::SCALE);
        n_s2_num      = {r_s1_mag_at, 16'b0} + N1_W'(n_s2_den >> 1);
        n_s2_lnbase   = LW'(LW'(r_s1_p) * LW'(dwp_pkg::LN2_Q))
                      + LW'(dwp_pkg::ln_tab(r_s1_idx))
                      - LW'(dwp_pkg::LN1E4_Q);
        n_s2_prod     = 24'(dwp_pkg::ln_diff(r_s1_idx)) * 24'(r_s1_w);
    end

    logic            r_s2_v;
    logic [N1_W-1:0] r_s2_num;
    logic [D1_W-1:0] r_s2_den;
    logic            r_s2_neg1;
    logic            r_s2_bad;
    logic [LW-1:0]   r_s2_lnbase;
    logic [11:0]     r_s2_lnfrac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_num    <= n_s2_num;
        r_s2_den    <= n_s2_den;
        r_s2_neg1   <= r_s1_tneg ^ r_s1_den1[17];
        r_s2_bad    <= r_s1_hzero | (r_s1_den1 == '0);
        r_s2_lnbase <= n_s2_lnbase;
        r_s2_lnfrac <= n_s2_prod[23:12];
    end

    // term divider, sign, invalid flag and ln ride alongside
    logic            d1_v;
    logic [N1_W-1:0] d1_q;
    logic [LW+13:0]  d1_sb;

    dwp_div #(.NUM_W(N1_W), .DEN_W(D1_W), .SB_W(LW + 14)) u_div_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_v),
        .i_num   (r_s2_num),
        .i_den   (r_s2_den),
        .i_sb    ({r_s2_neg1, r_s2_bad, r_s2_lnbase, r_s2_lnfrac}),
        .o_valid (d1_v),
        .o_quo   (d1_q),
        .o_sb    (d1_sb)
    );

    // alpha = term + ln
    logic          d1_neg;
    logic          d1_bad;
    logic [LW-1:0] d1_lnbase;
    logic [11:0]   d1_lnfrac;
    logic [AW-1:0] n_a_term;
    logic [AW-1:0] n_a_alpha;

    always_comb begin
        d1_neg    = d1_sb[LW+13];
        d1_bad    = d1_sb[LW+12];
        d1_lnbase = d1_sb[LW+11:12];
        d1_lnfrac = d1_sb[11:0];
        n_a_term  = d1_neg ? AW'(-{1'b0, d1_q[AW-2:0]}) : {1'b0, d1_q[AW-2:0]};
        n_a_alpha = n_a_term + {{(AW-LW){d1_lnbase[LW-1]}}, d1_lnbase}
                  + AW'(d1_lnfrac);
    end

    logic          r_a_v;
    logic [AW-1:0] r_a_alpha;
    logic [QW-1:0] r_a_aq;
    logic          r_a_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_alpha <= n_a_alpha;
        r_a_aq    <= r_aq;
        r_a_bad   <= d1_bad;
    end

    // stage b: a_q - alpha, |alpha|
    logic [AW:0]   n_b_den2;
    logic [AW-2:0] n_b_amag;

    always_comb begin
        n_b_den2 = {{(AW+1-QW){1'b0}}, r_a_aq} - {r_a_alpha[AW-1], r_a_alpha};
        n_b_amag = r_a_alpha[AW-1] ? (AW-1)'(-r_a_alpha) : r_a_alpha[AW-2:0];
    end

    logic          r_b_v;
    logic [AW:0]   r_b_den2;
    logic [AW-2:0] r_b_amag;
    logic          r_b_neg2;
    logic          r_b_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_den2 <= n_b_den2;
        r_b_amag <= n_b_amag;
        r_b_neg2 <= r_a_alpha[AW-1] ^ n_b_den2[AW];
        r_b_bad  <= r_a_bad | (n_b_den2 == '0);
    end

    // stage c: b*|alpha| in two partial products, |den2|
    logic          r_c_v;
    logic [34:0]   r_c_plo;
    logic [33:0]   r_c_phi;
    logic [D2_W-1:0] r_c_dmag;
    logic          r_c_neg2;
    logic          r_c_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_plo  <= 35'(r_b) * 35'(r_b_amag[18:0]);
        r_c_phi  <= 34'(r_b) * 34'(r_b_amag[AW-2:19]);
        r_c_dmag <= r_b_den2[AW] ? D2_W'(-r_b_den2) : r_b_den2[D2_W-1:0];
        r_c_neg2 <= r_b_neg2;
        r_c_bad  <= r_b_bad;
    end

    // stage d: rounded dividend for the dew divider
    logic            r_d_v;
    logic [N2_W-1:0] r_d_num;
    logic [D2_W-1:0] r_d_den;
    logic            r_d_neg2;
    logic            r_d_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_num  <= N2_W'({r_c_phi, 19'b0}) + N2_W'(r_c_plo) + N2_W'(r_c_dmag >> 1);
        r_d_den  <= r_c_dmag;
        r_d_neg2 <= r_c_neg2;
        r_d_bad  <= r_c_bad;
    end

    // dew divider
    logic            d2_v;
    logic [N2_W-1:0] d2_q;
    logic [1:0]      d2_sb;

    dwp_div #(.NUM_W(N2_W), .DEN_W(D2_W), .SB_W(2)) u_div_dew (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_d_v),
        .i_num   (r_d_num),
        .i_den   (r_d_den),
        .i_sb    ({r_d_neg2, r_d_bad}),
        .o_valid (d2_v),
        .o_quo   (d2_q),
        .o_sb    (d2_sb)
    );

    // sign, clamp and flags
    logic [15:0] n_o_dew;
    logic        n_o_valid;
    logic        n_o_ovf;

    always_comb begin
        n_o_dew   = 16'd0;
        n_o_valid = 1'b0;
        n_o_ovf   = 1'b0;
        if (!d2_sb[0]) begin
            n_o_valid = 1'b1;
            if (d2_sb[1]) begin
                if (d2_q > N2_W'(dwp_pkg::DEW_MIN_MAG)) begin
                    n_o_dew = 16'(-dwp_pkg::DEW_MIN_MAG);
                    n_o_ovf = 1'b1;
                end else begin
                    n_o_dew = 16'(-d2_q[15:0]);
                end
            end else begin
                if (d2_q > N2_W'(dwp_pkg::DEW_MAX)) begin
                    n_o_dew = 16'(dwp_pkg::DEW_MAX);
                    n_o_ovf = 1'b1;
                end else begin
                    n_o_dew = d2_q[15:0];
                end
            end
        end
    end

    // output register
    logic        r_o_v;
    logic [15:0] r_o_dew;
    logic        r_o_valid;
    logic        r_o_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else begin
            r_o_v <= d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_dew   <= n_o_dew;
        r_o_valid <= n_o_valid;
        r_o_ovf   <= n_o_ovf;
    end

    assign o_done      = r_o_v;
    assign o_dew_centi = $signed(r_o_dew);
    assign o_valid_res = r_o_valid;
    assign o_overflow  = r_o_ovf;

endmodule

FILE: src/dwp_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module dwp_div #(
    parameter int NUM_W = 47,
    parameter int DEN_W = 27,
    parameter int SB_W  = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [SB_W-1:0]  i_sb,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quo,
    output logic [SB_W-1:0]  o_sb
);

    logic [NUM_W-1:0] r_v;
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_acc [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [SB_W-1:0]  r_sb  [NUM_W];

    genvar k;
    for (k = 0; k < NUM_W; k++) begin : g_stage
        logic             v_in;
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [NUM_W-1:0] acc_in;
        logic [SB_W-1:0]  sb_in;
        logic [DEN_W:0]   trial;
        logic             qbit;
        logic [DEN_W-1:0] n_rem;
        logic [NUM_W-1:0] n_acc;

        // stage input from the ports or the previous stage
        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign rem_in = '0;
            assign den_in = i_den;
            assign acc_in = i_num;
            assign sb_in  = i_sb;
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign acc_in = r_acc[k-1];
            assign sb_in  = r_sb[k-1];
        end

        // shift in one dividend bit, subtract if it fits
        always_comb begin
            trial = {rem_in, acc_in[NUM_W-1]};
            qbit  = (trial >= {1'b0, den_in});
            n_rem = qbit ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
            n_acc = {acc_in[NUM_W-2:0], qbit};
        end

        // valid bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= v_in;
            end
        end

        // payload
        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_acc[k] <= n_acc;
            r_den[k] <= den_in;
            r_sb[k]  <= sb_in;
        end
    end

    assign o_valid = r_v[NUM_W-1];
    assign o_quo   = r_acc[NUM_W-1];
    assign o_sb    = r_sb[NUM_W-1];

endmodule
